// ===== design/scra_pkg.sv =====
// ----------------------------------------------------------------------------
// scra_pkg
// Shared widths, codes, reset values and types for the caption row allocator.
// ----------------------------------------------------------------------------
package scra_pkg;

	// field widths
	localparam int TIME_W  = 24;   // Q16.8 seconds
	localparam int WID_W   = 16;   // Q12.4 pixels
	localparam int TT_W    = 13;   // travel time register
	localparam int ROWS_W  = 5;    // rows_in_use register
	localparam int RH_W    = 10;   // row pitch, Q6.4
	localparam int ROW_W   = 5;    // row index on the ports
	localparam int EYE_W   = 10;
	localparam int ST_W    = 2;
	localparam int X_W     = 18;
	localparam int Y_W     = 15;

	// datapath widths
	localparam int SPAN_W  = 17;                // 6400 + width
	localparam int NUM_W   = TIME_W + SPAN_W;   // |elapsed| * span
	localparam int EDGE_W  = NUM_W + 3;         // signed right edge
	localparam int CNT_W   = $clog2(NUM_W + 1);

	// APB
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = APB_AW - 2;

	// constants
	localparam logic [SPAN_W-1:0] SCREEN_Q4 = 17'd6400;
	localparam logic [Y_W:0]      Y_BASE    = 16'd32;
	localparam int                X_MAX     = 131071;
	localparam int                X_MIN     = -131072;
	localparam logic [ROW_W-1:0]  NO_ROW    = 5'd31;

	// register map
	localparam logic [REG_IDX_W-1:0] REG_TRAVEL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROWS   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [TT_W-1:0]   TRAVEL_RST = 13'd2048;
	localparam logic [ROWS_W-1:0] ROWS_RST   = 5'd14;
	localparam logic [RH_W-1:0]   HEIGHT_RST = 10'd256;

	// request kinds
	localparam logic REQ_CLEAR = 1'b0;
	localparam logic REQ_PLACE = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_VISIBLE   = 2'd0,
		ST_OFFSCREEN = 2'd1,
		ST_PENDING   = 2'd2,
		ST_CLEARED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [TT_W-1:0]   travel_time;
		logic [ROWS_W-1:0] rows_in_use;
		logic [RH_W-1:0]   row_height;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [WID_W-1:0]  width;
	} row_rec_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
		row_rec_t         rec;
	} row_wr_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
		logic             rem_nz;
	} div_res_t;

endpackage

// ===== design/scra_if.sv =====
// ----------------------------------------------------------------------------
// scra_if
// Request and result channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface scra_req_if import scra_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [TIME_W-1:0]       now_time;
	logic [TIME_W-1:0]       start_time;
	logic [WID_W-1:0]        text_width;
	logic [ROW_W-1:0]        held_row;
	logic signed [EYE_W-1:0] eye_offset;

	modport source (
		output valid, req_type, now_time, start_time, text_width, held_row, eye_offset,
		input  ready
	);
	modport sink (
		input  valid, req_type, now_time, start_time, text_width, held_row, eye_offset,
		output ready
	);
endinterface

interface scra_rsp_if import scra_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ST_W-1:0]       status;
	logic [ROW_W-1:0]      row_index;
	logic signed [X_W-1:0] x_pos;
	logic [Y_W-1:0]        y_pos;

	modport source (
		output valid, status, row_index, x_pos, y_pos,
		input  ready
	);
	modport sink (
		input  valid, status, row_index, x_pos, y_pos,
		output ready
	);
endinterface

// ===== design/scrolling_caption_row_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// scrolling_caption_row_allocator_unit
// Row choice and screen position for right-to-left scrolling captions.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready): one request per caption per frame, or a clear
//    request (req_type 0) that frees every row after a seek or new data.
//  - rsp channel (valid/ready): exactly one result per request, in order.
//  - APB port: travel_time at 0x0, rows_in_use at 0x4, row_height at 0x8.
//    Write only while no request is outstanding.
//  - One request at a time: req.ready is high only while the sequencer idles.
//    Clear, not-started and expired requests go from the check state straight
//    to done. Held row or a free row available: one divide for its own position.
//    All rows busy: in addition, each row in use has its right edge computed
//    by its own pass through the shared multiplier and divider.
//  - A finished result sits in the output register; the next request is
//    accepted while it waits. If rsp stalls with a second result ready, the
//    sequencer holds in its done state and req.ready stays low.
//  - Reset clears the sequencer, the output valid bit and every row's busy
//    bit, and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module scrolling_caption_row_allocator_unit import scra_pkg::*; #(
	parameter int MAX_ROWS = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	scra_req_if.sink          req,
	scra_rsp_if.source        rsp
);

	localparam int XS_W = X_W + 2;
	localparam int YF_W = Y_W + 1;
	localparam int TS_W = TIME_W + 1;
	localparam logic signed [XS_W-1:0] XO_MAX = XS_W'(X_MAX);
	localparam logic signed [XS_W-1:0] XO_MIN = XS_W'(X_MIN);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_CHECK   = 8'b0000_0010,
		S_ROW_MUL = 8'b0000_0100,
		S_ROW_DIV = 8'b0000_1000,
		S_ROW_CMP = 8'b0001_0000,
		S_OWN_MUL = 8'b0010_0000,
		S_OWN_DIV = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration
	cfg_t              cfg;
	logic [ROWS_W-1:0] eff_rows;
	logic [TT_W-1:0]   t_eff;

	// latched request
	logic                    req_type_q;
	logic [TIME_W-1:0]       now_q;
	logic [TIME_W-1:0]       start_q;
	logic [WID_W-1:0]        width_q;
	logic [ROW_W-1:0]        held_q;
	logic signed [EYE_W-1:0] eye_q;

	// row walk
	logic [ROW_W-1:0]         scan_q;
	logic [ROW_W-1:0]         best_row_q;
	logic signed [EDGE_W-1:0] best_edge_q;
	logic                     best_ok_q;
	logic signed [EDGE_W-1:0] edge_q;
	logic                     neg_q;
	logic [SPAN_W-1:0]        span_q;
	logic [ROW_W-1:0]         row_q;
	logic                     rec_q;

	// pending result and output register
	status_t          res_status_q, out_status_q;
	logic [ROW_W-1:0] res_row_q, out_row_q;
	logic [X_W-1:0]   res_x_q, out_x_q;
	logic [Y_W-1:0]   res_y_q, out_y_q;
	logic             out_valid_q;
	logic             out_load;

	// row table
	row_wr_t           tbl_wr;
	row_rec_t          tbl_rec;
	logic              tbl_clear;
	logic              tbl_free_found;
	logic [ROW_W-1:0]  tbl_free_row;
	logic              tbl_all_free;

	// shared arithmetic
	div_res_t          div_res;
	logic              div_start;
	logic [TIME_W-1:0] mul_a;
	logic [SPAN_W-1:0] mul_b;
	logic [NUM_W-1:0]  prod;

	// decode and datapath
	logic              start_late, expired, held_ok, scan_last, better;
	logic [TIME_W:0]   row_dt;
	logic              row_neg;
	logic [TIME_W-1:0] row_mag;
	logic [SPAN_W-1:0] span_row, span_own;
	logic [TIME_W-1:0] own_dt;
	logic [EDGE_W-1:0] q_ext, rnz_ext, span_ext, edge_d;
	logic [SPAN_W-1:0] q_own;
	logic              offscreen;
	logic signed [XS_W-1:0] x_raw, xo_raw;
	logic [X_W-1:0]    x_sat;
	logic [YF_W-1:0]   y_full;
	logic [Y_W-1:0]    y_sat;

	scra_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scra_row_table #(.MAX_ROWS(MAX_ROWS)) u_rows (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (tbl_clear),
		.wr         (tbl_wr),
		.rd_row     (scan_q),
		.eff_rows   (eff_rows),
		.rd_rec     (tbl_rec),
		.free_found (tbl_free_found),
		.free_row   (tbl_free_row),
		.all_free   (tbl_all_free)
	);

	scra_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (t_eff),
		.res    (div_res)
	);

	// effective row count clamped to 1..MAX_ROWS, zero travel time read as one
	always_comb begin
		if (cfg.rows_in_use == '0) begin
			eff_rows = ROWS_W'(1);
		end else if (cfg.rows_in_use > ROWS_W'(MAX_ROWS)) begin
			eff_rows = ROWS_W'(MAX_ROWS);
		end else begin
			eff_rows = cfg.rows_in_use;
		end
	end
	assign t_eff = (cfg.travel_time == '0) ? TT_W'(1) : cfg.travel_time;

	// request classification
	assign start_late = start_q > now_q;
	assign expired    = ({1'b0, start_q} + TS_W'(t_eff)) < {1'b0, now_q};
	assign held_ok    = held_q < eff_rows;
	assign tbl_clear  = (state_q == S_CHECK) && (req_type_q == REQ_CLEAR);

	// right edge of a busy row: elapsed time may be negative
	assign row_dt   = {1'b0, now_q} - {1'b0, tbl_rec.start};
	assign row_neg  = row_dt[TIME_W];
	assign row_mag  = row_neg ? TIME_W'(-row_dt) : row_dt[TIME_W-1:0];
	assign span_row = SCREEN_Q4 + SPAN_W'(tbl_rec.width);

	// own caption: elapsed time is 0..T here
	assign own_dt   = now_q - start_q;
	assign span_own = SCREEN_Q4 + SPAN_W'(width_q);

	// one multiplier, result lands in the divider's registers
	assign mul_a     = (state_q == S_ROW_MUL) ? row_mag : own_dt;
	assign mul_b     = (state_q == S_ROW_MUL) ? span_row : span_own;
	assign prod      = NUM_W'(mul_a) * NUM_W'(mul_b);
	assign div_start = (state_q == S_ROW_MUL) || (state_q == S_OWN_MUL);

	// floor division: a negative numerator rounds away from zero
	assign q_ext    = {{(EDGE_W-NUM_W){1'b0}}, div_res.quo};
	assign rnz_ext  = {{(EDGE_W-1){1'b0}}, div_res.rem_nz};
	assign span_ext = {{(EDGE_W-SPAN_W){1'b0}}, span_q};
	assign edge_d   = neg_q ? (span_ext + q_ext + rnz_ext) : (span_ext - q_ext);

	// strict less-than keeps the lowest row on a tie
	assign scan_last = (scan_q + ROW_W'(1)) == eff_rows;
	assign better    = !best_ok_q || (edge_q < best_edge_q);

	// own position; quotient is at most 6400 + width
	assign q_own     = div_res.quo[SPAN_W-1:0];
	assign offscreen = q_own > span_own;  // right edge left of the screen
	assign x_raw     = $signed({{(XS_W-SPAN_W){1'b0}}, SCREEN_Q4})
	                 - $signed({{(XS_W-SPAN_W){1'b0}}, q_own});
	assign xo_raw    = x_raw + XS_W'(eye_q);

	always_comb begin
		if (xo_raw > XO_MAX) begin
			x_sat = XO_MAX[X_W-1:0];
		end else if (xo_raw < XO_MIN) begin
			x_sat = XO_MIN[X_W-1:0];
		end else begin
			x_sat = xo_raw[X_W-1:0];
		end
	end

	assign y_full = YF_W'(row_q) * YF_W'(cfg.row_height) + Y_BASE;
	assign y_sat  = y_full[Y_W] ? {Y_W{1'b1}} : y_full[Y_W-1:0];

	// record the new caption once its own position is known
	assign tbl_wr.en        = (state_q == S_OWN_DIV) && div_res.done && rec_q;
	assign tbl_wr.row       = row_q;
	assign tbl_wr.rec.start = start_q;
	assign tbl_wr.rec.width = width_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (req_type_q == REQ_CLEAR || start_late || expired) begin
					state_d = S_DONE;
				end else if (held_ok || tbl_free_found) begin
					state_d = S_OWN_MUL;
				end else begin
					state_d = S_ROW_MUL;
				end
			end
			S_ROW_MUL: state_d = S_ROW_DIV;
			S_ROW_DIV: begin
				if (div_res.done) state_d = S_ROW_CMP;
			end
			S_ROW_CMP: begin
				state_d = scan_last ? S_OWN_MUL : S_ROW_MUL;
			end
			S_OWN_MUL: state_d = S_OWN_DIV;
			S_OWN_DIV: begin
				if (div_res.done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			now_q      <= req.now_time;
			start_q    <= req.start_time;
			width_q    <= req.text_width;
			held_q     <= req.held_row;
			eye_q      <= req.eye_offset;
		end

		if (state_q == S_CHECK) begin
			scan_q    <= '0;
			best_ok_q <= 1'b0;
			rec_q     <= !held_ok;
			row_q     <= held_ok ? held_q : tbl_free_row;
			res_x_q   <= '0;
			res_y_q   <= '0;
			if (req_type_q == REQ_CLEAR) begin
				res_status_q <= ST_CLEARED;
				res_row_q    <= NO_ROW;
			end else begin
				res_status_q <= start_late ? ST_PENDING : ST_OFFSCREEN;
				res_row_q    <= held_q;
			end
		end

		if (state_q == S_ROW_MUL) begin
			neg_q  <= row_neg;
			span_q <= span_row;
		end

		if (state_q == S_ROW_DIV && div_res.done) begin
			edge_q <= edge_d;
		end

		if (state_q == S_ROW_CMP) begin
			if (better) begin
				best_ok_q   <= 1'b1;
				best_edge_q <= edge_q;
				best_row_q  <= scan_q;
			end
			if (scan_last) begin
				row_q <= better ? scan_q : best_row_q;
			end else begin
				scan_q <= scan_q + ROW_W'(1);
			end
		end

		if (state_q == S_OWN_DIV && div_res.done) begin
			res_status_q <= offscreen ? ST_OFFSCREEN : ST_VISIBLE;
			res_row_q    <= row_q;
			res_x_q      <= x_sat;
			res_y_q      <= y_sat;
		end

		if (out_load) begin
			out_status_q <= res_status_q;
			out_row_q    <= res_row_q;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.row_index = out_row_q;
	assign rsp.x_pos     = out_x_q;
	assign rsp.y_pos     = out_y_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_res.busy)
		else $error("divider restarted while busy");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OWN_MUL) |-> (row_q < eff_rows))
		else $error("chosen row beyond rows in use");

	a_clear_frees_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && req_type_q == REQ_CLEAR) |=> tbl_all_free)
		else $error("clear request left a row busy");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !rsp.ready) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule

// ===== design/scra_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scra_cfg_regs
// APB register file: travel time, rows in use, row pitch.
// ----------------------------------------------------------------------------
module scra_cfg_regs import scra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.travel_time <= TRAVEL_RST;
			cfg_q.rows_in_use <= ROWS_RST;
			cfg_q.row_height  <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TRAVEL: cfg_q.travel_time <= pwdata[TT_W-1:0];
				REG_ROWS:   cfg_q.rows_in_use <= pwdata[ROWS_W-1:0];
				REG_HEIGHT: cfg_q.row_height  <= pwdata[RH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRAVEL: prdata = {{(APB_DW-TT_W){1'b0}}, cfg_q.travel_time};
			REG_ROWS:   prdata = {{(APB_DW-ROWS_W){1'b0}}, cfg_q.rows_in_use};
			REG_HEIGHT: prdata = {{(APB_DW-RH_W){1'b0}}, cfg_q.row_height};
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== design/scra_divider.sv =====
// ----------------------------------------------------------------------------
// scra_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scra_divider import scra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [TT_W-1:0]  den,
	output div_res_t         res
);

	logic [NUM_W-1:0] quo_q;
	logic [TT_W-1:0]  rem_q;
	logic [TT_W-1:0]  den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [TT_W:0]    shifted;
	logic [TT_W:0]    diff;
	logic             fits;

	// remainder stays below the divisor, so the shifted value is below twice it
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[TT_W-1:0] : shifted[TT_W-1:0];
		end
	end

	assign res.busy   = busy_q;
	assign res.done   = done_q;
	assign res.quo    = quo_q;
	assign res.rem_nz = |rem_q;

endmodule

// ===== design/scra_row_table.sv =====
// ----------------------------------------------------------------------------
// scra_row_table
// Per-row occupancy bits and last caption start/width, lowest-free search.
// ----------------------------------------------------------------------------
module scra_row_table import scra_pkg::*; #(
	parameter int MAX_ROWS = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  row_wr_t           wr,
	input  logic [ROW_W-1:0]  rd_row,
	input  logic [ROWS_W-1:0] eff_rows,
	output row_rec_t          rd_rec,
	output logic              free_found,
	output logic [ROW_W-1:0]  free_row,
	output logic              all_free
);

	localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [MAX_ROWS-1:0] busy_q;
	row_rec_t            rec_q [MAX_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (clear) begin
			busy_q <= '0;
		end else if (wr.en) begin
			busy_q[wr.row[IDX_W-1:0]] <= 1'b1;
		end
	end

	// contents only matter once the busy bit is set
	always_ff @(posedge clk) begin
		if (wr.en) begin
			rec_q[wr.row[IDX_W-1:0]] <= wr.rec;
		end
	end

	assign rd_rec   = rec_q[rd_row[IDX_W-1:0]];
	assign all_free = (busy_q == '0);

	always_comb begin
		free_found = 1'b0;
		free_row   = '0;
		for (int i = MAX_ROWS - 1; i >= 0; i--) begin
			if (!busy_q[i] && (ROWS_W'(i) < eff_rows)) begin
				free_found = 1'b1;
				free_row   = ROW_W'(i);
			end
		end
	end

endmodule
